// ===== hw/rtl/text_console_writer_core_macros.svh =====
// assertion helpers for the console writer
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define TCW_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("console writer check failed");
// antecedent implies consequent in the next cycle
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("console writer check failed");
`else
`define TCW_ASSERT_NOW(lbl, ante, cons)
`define TCW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/tcw_pkg.sv =====
package tcw_pkg;

   // default screen geometry
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // field widths of the words on the ports
   localparam int COL_FIELD_W = 7;
   localparam int ROW_FIELD_W = 5;

   // attribute of a blank cell after a scroll
   localparam logic [7:0] BLANK_ATTR = 8'd15;

   typedef enum logic [1:0] {
      OP_PUT     = 2'd0,
      OP_NEWLINE = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_READ    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_SCROLL,
      ST_FILL
   } state_type;

   typedef struct packed {
      logic [7:0] attr;
      logic [7:0] ch;
   } cell_type;

   typedef struct packed {
      opcode_type                 opcode;
      logic [7:0]                 char_code;
      logic [3:0]                 fore_colour;
      logic [3:0]                 back_colour;
      logic [ROW_FIELD_W-1:0]     read_row;
      logic [COL_FIELD_W-1:0]     read_col;
   } req_type;

   typedef struct packed {
      logic [COL_FIELD_W-1:0]     cursor_col;
      logic [ROW_FIELD_W-1:0]     cursor_row;
      logic [7:0]                 cell_char;
      logic [7:0]                 cell_attr;
      logic                       scrolled;
   } rsp_type;

endpackage

// ===== hw/rtl/text_console_writer_core.sv =====
// text console writer: put, newline, clear and read over a ROWS x COLUMNS cell memory
// put or newline without scroll: result strobe in the cycle after accept, next word accepted next cycle
// read: cell registered in read port, then result registered; out-of-range read: no memory read
// clear: one cell written per cycle by the single write port
// scroll: row copy through read port, then bottom row fill; busy meanwhile
// reset: synchronous; busy stays high for a clearing pass of the memory
`include "text_console_writer_core_macros.svh"

module text_console_writer_core #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tcw_pkg::rsp_type rsp_data
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   tcw_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               op_clr_ff, op_clr_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   tcw_pkg::rsp_type   rsp_ff, rsp_in;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   tcw_pkg::cell_type  mem_wdata;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_raddr;
   tcw_pkg::cell_type  mem_q_ff;
   tcw_pkg::cell_type  mem [CELLS];

   logic               accept;
   logic               col_last;
   logic               row_last;
   logic               rd_in_range;
   logic [ADDR_W-1:0]  cur_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               cnt_at_copy_end;
   logic               cnt_at_end;

   // decode of the current word and counters
   assign accept          = start && !busy;
   assign busy            = (state_ff != tcw_pkg::ST_IDLE);
   assign col_last        = (col_ff == LAST_COL);
   assign row_last        = (row_ff == LAST_ROW);
   assign rd_in_range     = (32'(req_data.read_row) < ROWS) && (32'(req_data.read_col) < COLUMNS);
   assign cur_addr        = ADDR_W'(32'(row_ff) * COLUMNS + 32'(col_ff));
   assign rd_addr         = ADDR_W'(32'(req_data.read_row) * COLUMNS + 32'(req_data.read_col));
   assign cnt_at_copy_end = (32'(cnt_ff) == CELLS - COLUMNS);
   assign cnt_at_end      = (32'(cnt_ff) == CELLS - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.opcode)
                  tcw_pkg::OP_PUT: begin
                     if (col_last && row_last) state_in = tcw_pkg::ST_SCROLL;
                  end
                  tcw_pkg::OP_NEWLINE: begin
                     if (row_last) state_in = tcw_pkg::ST_SCROLL;
                  end
                  tcw_pkg::OP_CLEAR: state_in = tcw_pkg::ST_CLEAR;
                  tcw_pkg::OP_READ: begin
                     if (rd_in_range) state_in = tcw_pkg::ST_READ;
                  end
               endcase
            end
         end
         tcw_pkg::ST_CLEAR: begin
            if (cnt_at_end) state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_READ:  state_in = tcw_pkg::ST_IDLE;
         tcw_pkg::ST_SCROLL: begin
            if (cnt_at_copy_end) state_in = tcw_pkg::ST_FILL;
         end
         tcw_pkg::ST_FILL: begin
            if (cnt_at_end) state_in = tcw_pkg::ST_IDLE;
         end
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // cursor, sweep counter, memory controls and result word
   always_comb begin
      cnt_in        = cnt_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      op_clr_in     = op_clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_addr;
      mem_wdata     = '{attr: {req_data.back_colour, req_data.fore_colour},
                        ch: req_data.char_code};
      mem_re        = 1'b0;
      mem_raddr     = rd_addr;
      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.opcode)
                  tcw_pkg::OP_PUT: begin
                     mem_we = 1'b1;
                     if (col_last) begin
                        col_in = '0;
                        if (!row_last) row_in = row_ff + 1'b1;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  tcw_pkg::OP_NEWLINE: begin
                     col_in = '0;
                     if (!row_last) row_in = row_ff + 1'b1;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     op_clr_in = 1'b1;
                  end
                  tcw_pkg::OP_READ: begin
                     mem_re = rd_in_range;
                  end
               endcase
               cnt_in = '0;
               rsp_in = '{cursor_col: tcw_pkg::COL_FIELD_W'(col_in),
                          cursor_row: tcw_pkg::ROW_FIELD_W'(row_in),
                          cell_char: 8'd0, cell_attr: 8'd0, scrolled: 1'b0};
               // results that need no sweep and no memory read go out next cycle
               rsp_strobe_in = (state_in == tcw_pkg::ST_IDLE);
            end
         end
         tcw_pkg::ST_CLEAR: begin
            mem_we        = 1'b1;
            mem_waddr     = cnt_ff[ADDR_W-1:0];
            mem_wdata     = '0;
            cnt_in        = cnt_ff + 1'b1;
            // reset sweep ends silently, a clear word reports
            if (cnt_at_end) begin
               op_clr_in     = 1'b0;
               rsp_strobe_in = op_clr_ff;
               rsp_in        = '{cursor_col: tcw_pkg::COL_FIELD_W'(col_ff),
                                 cursor_row: tcw_pkg::ROW_FIELD_W'(row_ff),
                                 cell_char: 8'd0, cell_attr: 8'd0, scrolled: 1'b0};
            end
         end
         tcw_pkg::ST_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_in.cell_char = mem_q_ff.ch;
            rsp_in.cell_attr = mem_q_ff.attr;
         end
         tcw_pkg::ST_SCROLL: begin
            // read a cell one row below, write the cell read last cycle one row up
            mem_re    = !cnt_at_copy_end;
            mem_raddr = ADDR_W'(32'(cnt_ff) + COLUMNS);
            mem_we    = (cnt_ff != '0);
            mem_waddr = ADDR_W'(32'(cnt_ff) - 1);
            mem_wdata = mem_q_ff;
            if (!cnt_at_copy_end) cnt_in = cnt_ff + 1'b1;
         end
         tcw_pkg::ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[ADDR_W-1:0];
            mem_wdata = '{attr: tcw_pkg::BLANK_ATTR, ch: 8'd0};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_at_end) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{cursor_col: tcw_pkg::COL_FIELD_W'(col_ff),
                                 cursor_row: tcw_pkg::ROW_FIELD_W'(row_ff),
                                 cell_char: 8'd0, cell_attr: 8'd0, scrolled: 1'b1};
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcw_pkg::ST_CLEAR;
         cnt_ff        <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         op_clr_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         op_clr_ff     <= op_clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // cell memory: one write port, one registered read port; a read never
   // falls in the same cycle as a write to the same cell
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_q_ff <= mem[mem_raddr];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // cursor stays on the screen
   `TCW_ASSERT_NOW(a_cursor_range, 1'b1, (32'(col_ff) < COLUMNS) && (32'(row_ff) < ROWS))
   // a put either reports next cycle or starts a scroll
   `TCW_ASSERT_NEXT(a_put_done, accept && (req_data.opcode == tcw_pkg::OP_PUT),
      rsp_strobe_ff || (state_ff == tcw_pkg::ST_SCROLL))
   // the row copy never reads and writes the same cell in one cycle
   `TCW_ASSERT_NOW(a_copy_addr, mem_we && mem_re, mem_waddr != mem_raddr)
   // a scroll leaves the cursor on the bottom row
   `TCW_ASSERT_NOW(a_scroll_row, rsp_strobe_ff && rsp_ff.scrolled, row_ff == LAST_ROW)

endmodule
